// ===== design/v3alu_pkg.sv =====
// ----------------------------------------------------------------------------
// v3alu_pkg: shared types, constants and helpers of the vector3 ALU
// Operation codes, field widths and the saturation helpers used by the lane,
// root, divide and top-level files.
// ----------------------------------------------------------------------------
`default_nettype none

package v3alu_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MINLEN_W      = 31;
    localparam int OPND_W        = 33;
    localparam int PROD_W        = 66;
    localparam int WIDE_W        = 68;
    localparam int SQ_W          = 64;
    localparam int ROOT_W        = 32;
    localparam int SQRT_STAGES   = 32;
    localparam int CMD_W         = 4;
    localparam int S_TDATA_W     = 264;
    localparam int M_TDATA_W     = 168;

    localparam logic [MINLEN_W-1:0] MINLEN_RESET = 31'd7;

    localparam logic [CMD_W-1:0] CMD_ADD      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB      = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SCALE    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SCALEADD = 4'd3;
    localparam logic [CMD_W-1:0] CMD_BLEND    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DOT      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CROSS    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_DISTSQ   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_DIST     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_LEN      = 4'd9;
    localparam logic [CMD_W-1:0] CMD_NORM     = 4'd10;
    localparam logic [CMD_W-1:0] CMD_PLANE    = 4'd11;
    localparam logic [CMD_W-1:0] CMD_EQUAL    = 4'd12;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t WIDE_MAX = 68'sd2147483647;
    localparam wide_t WIDE_MIN = -68'sd2147483648;
    localparam word_t WORD_MAX = 32'sh7fffffff;
    localparam word_t WORD_MIN = 32'sh80000000;

    // per-lane result handed to the merge stage
    typedef struct packed {
        word_t r;
        wide_t term;
        logic  big;
    } lane_out_t;

    function automatic word_t sat_word(input wide_t v);
        word_t res;
        if (v > WIDE_MAX) begin
            res = WORD_MAX;
        end else if (v < WIDE_MIN) begin
            res = WORD_MIN;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic word_t sat_len(input logic [ROOT_W-1:0] len);
        word_t res;
        if (len[ROOT_W-1]) begin
            res = WORD_MAX;
        end else begin
            res = len;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/v3alu_lane.sv =====
// ----------------------------------------------------------------------------
// v3alu_lane: one component lane of the vector3 ALU
// Two registered stages: operand select and multiply, then shift, combine
// and saturate. Also hands a scalar term (product or square) to the merge.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_lane
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [CMD_W-1:0] cmd,
    input  word_t            a,
    input  word_t            b,
    input  word_t            s1,
    input  word_t            s2,
    input  word_t            cu0,
    input  word_t            cv0,
    input  word_t            cu1,
    input  word_t            cv1,
    output lane_out_t        lane_out
);

    localparam logic signed [OPND_W-1:0] D_LIM = 33'sd2147483648;

    logic signed [OPND_W-1:0] sum_w, diff_w;
    logic signed [OPND_W-1:0] op0a, op0b, op1a, op1b;
    logic signed [PROD_W-1:0] p0_next, p1_next;

    logic [CMD_W-1:0]         cmd_reg;
    logic signed [OPND_W-1:0] a_reg, sum_reg, diff_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg;

    logic signed [PROD_W-1:0] q0, q1;
    wide_t                    q0w, q1w, aw, sumw, diffw, p0w, r_wide;
    lane_out_t                lane_next, lane_reg;

    assign sum_w  = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    assign diff_w = {a[DATA_W-1], a} - {b[DATA_W-1], b};

    always_comb begin
        op0a = '0;
        op0b = '0;
        op1a = '0;
        op1b = '0;
        unique case (cmd)
            CMD_SCALE: begin
                op0a = {a[DATA_W-1], a};
                op0b = {s1[DATA_W-1], s1};
            end
            CMD_SCALEADD: begin
                op0a = {b[DATA_W-1], b};
                op0b = {s1[DATA_W-1], s1};
            end
            CMD_BLEND: begin
                op0a = {a[DATA_W-1], a};
                op0b = {s1[DATA_W-1], s1};
                op1a = {b[DATA_W-1], b};
                op1b = {s2[DATA_W-1], s2};
            end
            CMD_DOT: begin
                op0a = {a[DATA_W-1], a};
                op0b = {b[DATA_W-1], b};
            end
            CMD_CROSS: begin
                op0a = {cu0[DATA_W-1], cu0};
                op0b = {cv0[DATA_W-1], cv0};
                op1a = {cu1[DATA_W-1], cu1};
                op1b = {cv1[DATA_W-1], cv1};
            end
            CMD_DISTSQ, CMD_DIST: begin
                op0a = diff_w;
                op0b = diff_w;
            end
            CMD_LEN, CMD_NORM, CMD_PLANE: begin
                op0a = {a[DATA_W-1], a};
                op0b = {a[DATA_W-1], a};
            end
            default: begin
                op0a = '0;
            end
        endcase
    end

    assign p0_next = op0a * op0b;
    assign p1_next = op1a * op1b;

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd_reg  <= cmd;
            a_reg    <= {a[DATA_W-1], a};
            sum_reg  <= sum_w;
            diff_reg <= diff_w;
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
        end
    end

    assign q0    = p0_reg >>> FRAC_BITS;
    assign q1    = p1_reg >>> FRAC_BITS;
    assign q0w   = {{(WIDE_W-PROD_W){q0[PROD_W-1]}}, q0};
    assign q1w   = {{(WIDE_W-PROD_W){q1[PROD_W-1]}}, q1};
    assign p0w   = {{(WIDE_W-PROD_W){p0_reg[PROD_W-1]}}, p0_reg};
    assign aw    = {{(WIDE_W-OPND_W){a_reg[OPND_W-1]}}, a_reg};
    assign sumw  = {{(WIDE_W-OPND_W){sum_reg[OPND_W-1]}}, sum_reg};
    assign diffw = {{(WIDE_W-OPND_W){diff_reg[OPND_W-1]}}, diff_reg};

    always_comb begin
        r_wide         = '0;
        lane_next.term = '0;
        unique case (cmd_reg)
            CMD_ADD:      r_wide = sumw;
            CMD_SUB:      r_wide = diffw;
            CMD_SCALE:    r_wide = q0w;
            CMD_SCALEADD: r_wide = aw + q0w;
            CMD_BLEND:    r_wide = q0w + q1w;
            CMD_CROSS:    r_wide = q0w - q1w;
            CMD_DOT, CMD_DISTSQ: lane_next.term = q0w;
            CMD_DIST, CMD_LEN, CMD_NORM, CMD_PLANE: lane_next.term = p0w;
            default:      r_wide = '0;
        endcase
        lane_next.r   = sat_word(r_wide);
        lane_next.big = (diff_reg > D_LIM) || (diff_reg < -D_LIM);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

// ===== design/v3alu_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3alu_sqrt: pipelined integer square root
// Digit-by-digit floor root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_sqrt
    import v3alu_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [SQ_W-1:0]   sq_in,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W-1:0] n_reg   [SQRT_STAGES];
    logic [SQ_W-1:0] res_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stg
        localparam logic [SQ_W-1:0] BIT = 64'd1 << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] n_in, r_in, trial;

        if (k == 0) begin : g_first
            assign n_in = sq_in;
            assign r_in = '0;
        end else begin : g_rest
            assign n_in = n_reg[k-1];
            assign r_in = res_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (n_in >= trial) begin
                    n_reg[k]   <= n_in - trial;
                    res_reg[k] <= (r_in >> 1) + BIT;
                end else begin
                    n_reg[k]   <= n_in;
                    res_reg[k] <= r_in >> 1;
                end
            end
        end
    end

    assign root = res_reg[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== design/v3alu_div.sv =====
// ----------------------------------------------------------------------------
// v3alu_div: pipelined restoring divider for normalize
// Computes floor(mag * 2^FRAC_BITS / len), one quotient bit per stage. The
// quotient never exceeds 2^FRAC_BITS because len is at least mag.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_div
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [DATA_W-1:0] mag,
    input  logic [ROOT_W-1:0] len,
    output logic [FRAC_BITS:0] quot
);

    localparam int STAGES = FRAC_BITS + 1;
    localparam int REM_W  = ROOT_W + 1;

    logic [REM_W-1:0]   rem_reg [STAGES];
    logic [ROOT_W-1:0]  len_reg [STAGES];
    logic [FRAC_BITS:0] q_reg   [STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_stg
        logic [REM_W-1:0]   rem_in, sh;
        logic [ROOT_W-1:0]  len_in;
        logic [FRAC_BITS:0] q_in;
        logic               bit_in, ge;

        if (j == 0) begin : g_first
            // high part of the numerator; the low bit of mag is shifted in at this stage
            assign rem_in = {2'b00, mag[DATA_W-1:1]};
            assign len_in = len;
            assign q_in   = '0;
            assign bit_in = mag[0];
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign len_in = len_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign bit_in = 1'b0;
        end

        assign sh = {rem_in[REM_W-2:0], bit_in};
        assign ge = sh >= {1'b0, len_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= ge ? sh - {1'b0, len_in} : sh;
                len_reg[j] <= len_in;
                q_reg[j]   <= {q_in[FRAC_BITS-1:0], ge};
            end
        end
    end

    assign quot = q_reg[STAGES-1];

endmodule

`default_nettype wire

// ===== design/vector3_alu.sv =====
// ----------------------------------------------------------------------------
// vector3_alu: three-component Q16.16 vector unit
// Three component lanes, a merge stage, a pipelined root, three pipelined
// dividers and a plane stage; one result beat per input beat.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    s_tdata  (cmd, a, b, scales)
//  m_        out        m_tvalid/m_tready    m_tdata  (vector, w, scalar, flag)
//  cfg_      in         cfg_wr_en            cfg_wr_data (min_length)
//
//  Throughput one beat per cycle while the output is not stalled; the depth is
//  set by the 32-stage square root and the FRAC_BITS+1 stage divider.
//  Reset clears all valid bits and loads min_length with 7.
//  A stalled output beat freezes the whole pipeline and holds off the input;
//  while the output register is empty or being taken, a beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_alu
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // cmd, a_x, a_y, a_z, b_x, b_y, b_z, scale_a, scale_b
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // result_x, result_y, result_z, result_w, scalar_out, equal_flag
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_wr_en,
    input  logic [MINLEN_W-1:0]  cfg_wr_data
);

    localparam int DIV_STAGES = FRAC_BITS + 1;
    localparam int NVLD       = 3 + SQRT_STAGES + DIV_STAGES + 2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        word_t [2:0]      a;
        word_t [2:0]      b;
        word_t [2:0]      r;
        word_t            sc;
        logic             eq;
        logic             big;
    } tag_t;

    typedef struct packed {
        tag_t              t;
        logic [ROOT_W-1:0] len;
    } tag2_t;

    logic                en;
    logic [NVLD-1:0]     vld_reg;
    logic                m_tvalid_reg;
    logic [MINLEN_W-1:0] min_length_reg;

    word_t               in_a [3];
    word_t               in_b [3];
    word_t               in_s1, in_s2;
    logic [CMD_W-1:0]    in_cmd;
    tag_t                in_tag, st1_reg, st2_reg, st3_next, st3_reg;
    lane_out_t           lane_out [3];
    wide_t               tsum;
    logic [SQ_W-1:0]     sq_reg;
    logic [ROOT_W-1:0]   root;
    tag_t                tagd_reg [SQRT_STAGES];
    tag2_t               tagq_reg [DIV_STAGES];
    logic [FRAC_BITS:0]  quot [3];
    tag2_t               tp_reg, tq_reg;
    word_t               n_reg [3];
    logic signed [2*DATA_W-1:0] pb_reg [3];
    logic                norm_ok;
    wide_t               w_sum;
    word_t               res_x_reg, res_y_reg, res_z_reg, res_w_reg, scalar_reg;
    logic                eq_reg;
    word_t [2:0]         vec_next;
    word_t               w_next, sc_next;

    assign en       = ~m_tvalid_reg | m_tready;
    assign s_tready = en;

    assign in_cmd  = s_tdata[3:0];
    assign in_a[0] = s_tdata[35:4];
    assign in_a[1] = s_tdata[67:36];
    assign in_a[2] = s_tdata[99:68];
    assign in_b[0] = s_tdata[131:100];
    assign in_b[1] = s_tdata[163:132];
    assign in_b[2] = s_tdata[195:164];
    assign in_s1   = s_tdata[227:196];
    assign in_s2   = s_tdata[259:228];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg <= MINLEN_RESET;
        end else if (cfg_wr_en) begin
            min_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[NVLD-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[NVLD-1];
        end
    end

    always_comb begin
        in_tag     = '0;
        in_tag.cmd = in_cmd;
        for (int i = 0; i < 3; i++) begin
            in_tag.a[i] = in_a[i];
            in_tag.b[i] = in_b[i];
        end
        in_tag.eq = (in_a[0] == in_b[0]) && (in_a[1] == in_b[1]) && (in_a[2] == in_b[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_reg <= in_tag;
            st2_reg <= st1_reg;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        v3alu_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .aclk     (aclk),
            .en       (en),
            .cmd      (in_cmd),
            .a        (in_a[i]),
            .b        (in_b[i]),
            .s1       (in_s1),
            .s2       (in_s2),
            .cu0      (in_a[(i+1)%3]),
            .cv0      (in_b[(i+2)%3]),
            .cu1      (in_a[(i+2)%3]),
            .cv1      (in_b[(i+1)%3]),
            .lane_out (lane_out[i])
        );
    end

    // merge: sum the lane terms for dot, squared distance and the root input
    assign tsum = lane_out[0].term + lane_out[1].term + lane_out[2].term;

    always_comb begin
        st3_next      = st2_reg;
        st3_next.big  = lane_out[0].big | lane_out[1].big | lane_out[2].big;
        for (int i = 0; i < 3; i++) begin
            st3_next.r[i] = lane_out[i].r;
        end
        if (st2_reg.cmd == CMD_DOT || st2_reg.cmd == CMD_DISTSQ) begin
            st3_next.sc = sat_word(tsum);
        end else begin
            st3_next.sc = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st3_reg <= st3_next;
            sq_reg  <= tsum[SQ_W-1:0];
        end
    end

    v3alu_sqrt u_sqrt (
        .aclk  (aclk),
        .en    (en),
        .sq_in (sq_reg),
        .root  (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            tagd_reg[0] <= st3_reg;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                tagd_reg[k] <= tagd_reg[k-1];
            end
            tagq_reg[0] <= '{t: tagd_reg[SQRT_STAGES-1], len: root};
            for (int k = 1; k < DIV_STAGES; k++) begin
                tagq_reg[k] <= tagq_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        word_t            av;
        logic [DATA_W-1:0] mag;
        assign av  = tagd_reg[SQRT_STAGES-1].a[i];
        assign mag = av[DATA_W-1] ? DATA_W'(-av) : DATA_W'(av);

        v3alu_div #(
            .FRAC_BITS(FRAC_BITS)
        ) u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (mag),
            .len  (root),
            .quot (quot[i])
        );
    end

    assign norm_ok = (tagq_reg[DIV_STAGES-1].len != '0)
                  && (tagq_reg[DIV_STAGES-1].len >= {1'b0, min_length_reg});

    // normalized vector, then plane products
    always_ff @(posedge aclk) begin
        if (en) begin
            tp_reg <= tagq_reg[DIV_STAGES-1];
            for (int i = 0; i < 3; i++) begin
                if (!norm_ok) begin
                    n_reg[i] <= tagq_reg[DIV_STAGES-1].t.a[i];
                end else if (tagq_reg[DIV_STAGES-1].t.a[i][DATA_W-1]) begin
                    n_reg[i] <= -$signed({{(DATA_W-FRAC_BITS-1){1'b0}}, quot[i]});
                end else begin
                    n_reg[i] <= $signed({{(DATA_W-FRAC_BITS-1){1'b0}}, quot[i]});
                end
            end
            tq_reg <= tp_reg;
            for (int i = 0; i < 3; i++) begin
                pb_reg[i] <= $signed(tp_reg.t.b[i]) * n_reg[i];
            end
        end
    end

    word_t n_q_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n_q_reg[i] <= n_reg[i];
            end
        end
    end

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < 3; i++) begin
            w_sum = w_sum + {{(WIDE_W-2*DATA_W){pb_reg[i][2*DATA_W-1]}},
                             (pb_reg[i] >>> FRAC_BITS)};
        end
        vec_next = '0;
        w_next   = '0;
        sc_next  = '0;
        unique case (tq_reg.t.cmd)
            CMD_ADD, CMD_SUB, CMD_SCALE, CMD_SCALEADD, CMD_BLEND, CMD_CROSS: begin
                vec_next = tq_reg.t.r;
            end
            CMD_DOT, CMD_DISTSQ: sc_next = tq_reg.t.sc;
            CMD_DIST: sc_next = tq_reg.t.big ? WORD_MAX : sat_len(tq_reg.len);
            CMD_LEN:  sc_next = sat_len(tq_reg.len);
            CMD_NORM: begin
                sc_next = sat_len(tq_reg.len);
                for (int i = 0; i < 3; i++) begin
                    vec_next[i] = n_q_reg[i];
                end
            end
            CMD_PLANE: begin
                w_next = sat_word(w_sum);
                for (int i = 0; i < 3; i++) begin
                    vec_next[i] = n_q_reg[i];
                end
            end
            default: vec_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_x_reg  <= vec_next[0];
            res_y_reg  <= vec_next[1];
            res_z_reg  <= vec_next[2];
            res_w_reg  <= w_next;
            scalar_reg <= sc_next;
            eq_reg     <= (tq_reg.t.cmd == CMD_EQUAL) ? tq_reg.t.eq : 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, eq_reg, scalar_reg, res_w_reg, res_z_reg, res_y_reg, res_x_reg};

    // equality beats carry nothing but the flag
    a_eq_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[160] |-> m_tdata[159:0] == '0)
        else $error("equal flag with other fields set");

    // a plane term excludes scalar and flag
    a_w_plane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[127:96] != '0 |-> m_tdata[160:128] == '0)
        else $error("plane term with scalar or flag set");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
